[rtl/core/gha_pkg.sv]
// Shared types and constants for the generational handle allocator.
package gha_pkg;

    localparam int POOL_SLOTS = 256;
    localparam int IDX_W      = 8;
    localparam int GEN_W      = 32;
    localparam int CNT_W      = 9;

    localparam logic [CNT_W-1:0] POOL_SLOTS_C = CNT_W'(POOL_SLOTS);

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_CHECK   = 2'd2,
        KIND_CLEAR   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        logic             alive;
        logic [GEN_W-1:0] gen;
    } t_slot_word;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        t_slot_word       word;
    } t_slot_wr;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [GEN_W-1:0] gen;
    } t_stack_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_stack_entry     entry;
    } t_stack_wr;

endpackage

[rtl/core/gha_slot_table.sv]
// Slot table: alive bit and generation per slot, registered read with write bypass.
module gha_slot_table import gha_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_rd_idx,
    input  t_slot_wr         i_wr,
    output t_slot_word       o_rd_word
);

    t_slot_word r_mem [POOL_SLOTS];
    t_slot_word r_rd_word;
    t_slot_word r_fw_word;
    logic       r_fw_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.word;
        end
        r_rd_word <= r_mem[i_rd_idx];
        r_fw_word <= i_wr.word;
    end

    // The read at this edge misses a write at the same edge: remember it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_hit <= 1'b0;
        end else begin
            r_fw_hit <= i_wr.en && (i_wr.idx == i_rd_idx);
        end
    end

    assign o_rd_word = r_fw_hit ? r_fw_word : r_rd_word;

endmodule

[rtl/core/gha_free_stack.sv]
// Free-index stack storage: index plus its current generation, registered top read.
module gha_free_stack import gha_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_rd_addr,
    input  t_stack_wr        i_wr,
    output t_stack_entry     o_top
);

    t_stack_entry r_mem [POOL_SLOTS];
    t_stack_entry r_rd_entry;
    t_stack_entry r_fw_entry;
    logic         r_fw_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
        r_rd_entry <= r_mem[i_rd_addr];
        r_fw_entry <= i_wr.entry;
    end

    // A push at the edge that reads the new top hands its entry over directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_hit <= 1'b0;
        end else begin
            r_fw_hit <= i_wr.en && (i_wr.addr == i_rd_addr);
        end
    end

    assign o_top = r_fw_hit ? r_fw_entry : r_rd_entry;

endmodule

[rtl/core/generational_handle_allocator.sv]
// Top level: request stage, allocator decision logic, counters and result register.
//
// Accepts one request per clock whenever busy is low. Busy is high during reset
// and clears at the clock edge after reset is released. Each request yields exactly
// one result. o_done is high for a single cycle per request: the accepted request
// is registered in r_valid, then o_done is registered from r_valid together with
// the result. The receiver cannot stall, so results must be taken as they appear.
// The request stage is there for the registered reads of the slot table and
// the free-stack memory, which are addressed at the accept edge and bypassed
// from the write of the request just ahead. Freed slots are
// reused most recent first; a fresh slot is taken only when none is free. The
// stack entry carries the slot's generation, so an allocation needs no second
// table read. Slots never handed out are fenced off by the high-water mark, so
// no clearing pass runs after reset or on a clear request.
module generational_handle_allocator import gha_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [1:0]       i_kind,
    input  logic [IDX_W-1:0] i_slot_index,
    input  logic [GEN_W-1:0] i_handle_generation,
    output logic             busy,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [IDX_W-1:0] o_out_index,
    output logic [GEN_W-1:0] o_out_generation
);

    logic             r_busy;
    logic             r_valid;
    t_kind            r_kind;
    logic [IDX_W-1:0] r_idx;
    logic [GEN_W-1:0] r_gen;

    logic [CNT_W-1:0] r_free_count;
    logic [CNT_W-1:0] r_high_water;
    logic [CNT_W-1:0] n_free_count;
    logic [CNT_W-1:0] n_high_water;

    logic             r_done;
    t_status          r_status;
    logic [IDX_W-1:0] r_out_idx;
    logic [GEN_W-1:0] r_out_gen;
    t_status          n_status;
    logic [IDX_W-1:0] n_out_idx;
    logic [GEN_W-1:0] n_out_gen;

    logic             w_accept;
    t_slot_word       w_slot_word;
    t_slot_wr         w_slot_wr;
    t_stack_entry     w_top;
    t_stack_wr        w_stack_wr;
    logic [CNT_W-1:0] w_top_ptr;
    logic [GEN_W-1:0] w_reuse_gen;
    logic             w_handle_ok;

    assign w_accept = start && !r_busy;

    gha_slot_table u_slot_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_idx  (i_slot_index),
        .i_wr      (w_slot_wr),
        .o_rd_word (w_slot_word)
    );

    // Read the entry that will be the stack top once the current request retires.
    assign w_top_ptr = n_free_count - CNT_W'(1);

    gha_free_stack u_free_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_top_ptr[IDX_W-1:0]),
        .i_wr      (w_stack_wr),
        .o_top     (w_top)
    );

    assign w_handle_ok = (r_idx != '0)
                      && ({1'b0, r_idx} < r_high_water)
                      && w_slot_word.alive
                      && (w_slot_word.gen == r_gen);

    // A reused slot whose generation wrapped restarts at one.
    assign w_reuse_gen = (w_top.gen == '0) ? GEN_W'(1) : w_top.gen;

    always_comb begin
        n_free_count = r_free_count;
        n_high_water = r_high_water;
        n_status     = ST_OK;
        n_out_idx    = '0;
        n_out_gen    = '0;
        w_slot_wr    = '{en: 1'b0, idx: r_idx,
                         word: '{alive: 1'b0, gen: r_gen + GEN_W'(1)}};
        w_stack_wr   = '{en: 1'b0, addr: r_free_count[IDX_W-1:0],
                         entry: '{idx: r_idx, gen: r_gen + GEN_W'(1)}};
        if (r_valid) begin
            case (r_kind)
                KIND_ALLOC: begin
                    if (r_free_count != '0) begin
                        n_free_count   = r_free_count - CNT_W'(1);
                        n_out_idx      = w_top.idx;
                        n_out_gen      = w_reuse_gen;
                        w_slot_wr.en   = 1'b1;
                        w_slot_wr.idx  = w_top.idx;
                        w_slot_wr.word = '{alive: 1'b1, gen: w_reuse_gen};
                    end else if (r_high_water < POOL_SLOTS_C) begin
                        n_high_water   = r_high_water + CNT_W'(1);
                        n_out_idx      = r_high_water[IDX_W-1:0];
                        n_out_gen      = GEN_W'(1);
                        w_slot_wr.en   = 1'b1;
                        w_slot_wr.idx  = r_high_water[IDX_W-1:0];
                        w_slot_wr.word = '{alive: 1'b1, gen: GEN_W'(1)};
                    end else begin
                        n_status = ST_FULL;
                    end
                end
                KIND_RELEASE: begin
                    if (w_handle_ok) begin
                        w_slot_wr.en = 1'b1;
                        if (r_free_count < POOL_SLOTS_C) begin
                            w_stack_wr.en = 1'b1;
                            n_free_count  = r_free_count + CNT_W'(1);
                        end
                    end else begin
                        n_status = ST_INVALID;
                    end
                end
                KIND_CHECK: begin
                    n_status = w_handle_ok ? ST_OK : ST_INVALID;
                end
                KIND_CLEAR: begin
                    n_free_count = '0;
                    n_high_water = CNT_W'(1);
                end
                default: begin
                    n_status = ST_INVALID;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b1;
            r_valid      <= 1'b0;
            r_done       <= 1'b0;
            r_free_count <= '0;
            r_high_water <= CNT_W'(1);
        end else begin
            r_busy       <= 1'b0;
            r_valid      <= w_accept;
            r_done       <= r_valid;
            r_free_count <= n_free_count;
            r_high_water <= n_high_water;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= t_kind'(i_kind);
            r_idx  <= i_slot_index;
            r_gen  <= i_handle_generation;
        end
        r_status  <= n_status;
        r_out_idx <= n_out_idx;
        r_out_gen <= n_out_gen;
    end

    assign busy             = r_busy;
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_out_index      = r_out_idx;
    assign o_out_generation = r_out_gen;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_count <= POOL_SLOTS_C) && (r_free_count < r_high_water))
        else $error("free count out of range");

    a_high_water_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_high_water != '0) && (r_high_water <= POOL_SLOTS_C))
        else $error("high-water mark out of range");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##2 o_done)
        else $error("request did not produce a result two cycles later");

    a_empty_unless_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_OK)) |-> (o_out_index == '0) && (o_out_generation == '0))
        else $error("failed request returned a handle");

    a_handle_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_out_index != '0)) |-> (o_out_generation != '0))
        else $error("allocated handle has generation zero");

endmodule
